@@ rtl/core/jfhs_pkg.sv @@
// jfhs_pkg: beat types, parser phase codes and marker constants for the
// JPEG frame header scanner. No dependencies.
package jfhs_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] width;
		logic [15:0] height;
		logic        progressive;
	} out_t;

	localparam logic [15:0] LIMIT_RESET = 16'd8192;

	localparam logic [3:0] PH_SOI0   = 4'd0;
	localparam logic [3:0] PH_SOI1   = 4'd1;
	localparam logic [3:0] PH_WANTFF = 4'd2;
	localparam logic [3:0] PH_MARKER = 4'd3;
	localparam logic [3:0] PH_LENHI  = 4'd4;
	localparam logic [3:0] PH_LENLO  = 4'd5;
	localparam logic [3:0] PH_SKIP   = 4'd6;
	localparam logic [3:0] PH_PREC   = 4'd7;
	localparam logic [3:0] PH_HHI    = 4'd8;
	localparam logic [3:0] PH_HLO    = 4'd9;
	localparam logic [3:0] PH_WHI    = 4'd10;
	localparam logic [3:0] PH_WLO    = 4'd11;

	localparam logic [7:0] MK_FILL  = 8'hFF;
	localparam logic [7:0] MK_SOI   = 8'hD8;
	localparam logic [7:0] MK_SOS   = 8'hDA;
	localparam logic [7:0] MK_TEM   = 8'h01;
	localparam logic [7:0] MK_RST0  = 8'hD0;
	localparam logic [7:0] MK_EOI   = 8'hD9;
	localparam logic [7:0] MK_SOF0  = 8'hC0;
	localparam logic [7:0] MK_SOF15 = 8'hCF;
	localparam logic [7:0] MK_DHT   = 8'hC4;
	localparam logic [7:0] MK_JPG   = 8'hC8;
	localparam logic [7:0] MK_DAC   = 8'hCC;
	localparam logic [7:0] MK_SOF2  = 8'hC2;

	localparam logic [15:0] LEN_MIN     = 16'd2;
	localparam logic [15:0] LEN_SOF_MIN = 16'd7;

	function automatic logic sof_code(input logic [7:0] m);
		logic excl;
		excl = (m == MK_DHT) || (m == MK_JPG) || (m == MK_DAC);
		return !excl && (m >= MK_SOF0) && (m <= MK_SOF15);
	endfunction

	// C2, C6, CA, CE: high nibble C, low two bits 2'b10
	function automatic logic prog_code(input logic [7:0] m);
		return (m[7:4] == MK_SOF2[7:4]) && (m[1:0] == MK_SOF2[1:0]);
	endfunction

endpackage

@@ rtl/core/jpeg_frame_header_scanner_core.sv @@
// jpeg_frame_header_scanner_core: top level of the JPEG SOF scanner.
// Depends on jfhs_pkg, jfhs_cfg, jfhs_parse.
//
//  channel | dir | handshake            | beat
//  --------+-----+----------------------+----------------------------------
//  in      | in  | in_valid / in_ready  | in_data  (data_byte, last_byte)
//  out     | out | out_valid / out_ready| out_data (ok, width, height, progr.)
//  cfg     | in  | cfg_valid / cfg_ready| cfg_data (byte_limit)
//
// One byte per cycle sustained while the output is not held. A byte is
// registered in the s1 input register, the parser steps on it and any result
// lands in the output register. Reset clears parser state and sets
// byte_limit to 8192. A held output stalls s1 only when s1 has a byte;
// in_ready follows out_ready combinationally. cfg_ready is always high.
module jpeg_frame_header_scanner_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  jfhs_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output jfhs_pkg::out_t  out_data,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [15:0]     cfg_data
);

	logic           valid_s1;
	jfhs_pkg::in_t  beat_s1;
	logic           advance;
	logic           res_fire;
	jfhs_pkg::out_t res;
	logic [15:0]    byte_limit;
	logic           out_valid_q;
	jfhs_pkg::out_t out_q;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	jfhs_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.byte_limit (byte_limit)
	);

	jfhs_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.beat       (beat_s1),
		.byte_limit (byte_limit),
		.res_fire   (res_fire),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) beat_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_fire) out_q <= res;
	end

endmodule

@@ rtl/core/jfhs_parse.sv @@
// jfhs_parse: per-image parser state and the one-byte step logic.
// Depends on jfhs_pkg.
module jfhs_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  jfhs_pkg::in_t    beat,
	input  logic [15:0]      byte_limit,
	output logic             res_fire,
	output jfhs_pkg::out_t   res
);

	logic [3:0]  phase_q, phase_n;
	logic [15:0] byte_count_q;
	logic [15:0] skip_left_q, skip_left_n;
	logic [7:0]  marker_q, marker_n;
	logic [7:0]  len_hi_q, len_hi_n;
	logic [15:0] height_q, height_n;
	logic [7:0]  width_hi_q, width_hi_n;
	logic        decided_q;

	logic        take;
	logic        fail;
	logic        win;
	logic [7:0]  b;
	logic [15:0] len;
	logic [15:0] skip_dec;
	logic [15:0] wval;
	logic [16:0] cnt_inc;

	assign b        = beat.data_byte;
	assign len      = {len_hi_q, b};
	assign skip_dec = skip_left_q - 16'd1;
	assign wval     = {width_hi_q, b};
	assign cnt_inc  = {1'b0, byte_count_q} + 17'd1;
	assign take     = !decided_q && (byte_count_q < byte_limit);

	always_comb begin
		phase_n     = phase_q;
		skip_left_n = skip_left_q;
		marker_n    = marker_q;
		len_hi_n    = len_hi_q;
		height_n    = height_q;
		width_hi_n  = width_hi_q;
		fail        = 1'b0;
		win         = 1'b0;
		if (take) begin
			case (phase_q)
				jfhs_pkg::PH_SOI0: begin
					if (b != jfhs_pkg::MK_FILL) fail = 1'b1;
					else phase_n = jfhs_pkg::PH_SOI1;
				end
				jfhs_pkg::PH_SOI1: begin
					if (b != jfhs_pkg::MK_SOI) fail = 1'b1;
					else phase_n = jfhs_pkg::PH_WANTFF;
				end
				jfhs_pkg::PH_WANTFF: begin
					if (b != jfhs_pkg::MK_FILL) fail = 1'b1;
					else phase_n = jfhs_pkg::PH_MARKER;
				end
				jfhs_pkg::PH_MARKER: begin
					if (b == jfhs_pkg::MK_FILL) begin
						phase_n = jfhs_pkg::PH_MARKER;
					end else if (b == jfhs_pkg::MK_TEM ||
							(b >= jfhs_pkg::MK_RST0 && b <= jfhs_pkg::MK_EOI)) begin
						phase_n = jfhs_pkg::PH_WANTFF;
					end else if (b == jfhs_pkg::MK_SOS) begin
						fail = 1'b1;
					end else begin
						marker_n = b;
						phase_n  = jfhs_pkg::PH_LENHI;
					end
				end
				jfhs_pkg::PH_LENHI: begin
					len_hi_n = b;
					phase_n  = jfhs_pkg::PH_LENLO;
				end
				jfhs_pkg::PH_LENLO: begin
					if (len < jfhs_pkg::LEN_MIN) begin
						fail = 1'b1;
					end else if (jfhs_pkg::sof_code(marker_q)) begin
						if (len < jfhs_pkg::LEN_SOF_MIN) fail = 1'b1;
						else phase_n = jfhs_pkg::PH_PREC;
					end else begin
						skip_left_n = len - jfhs_pkg::LEN_MIN;
						phase_n = (len == jfhs_pkg::LEN_MIN) ?
							jfhs_pkg::PH_WANTFF : jfhs_pkg::PH_SKIP;
					end
				end
				jfhs_pkg::PH_SKIP: begin
					skip_left_n = skip_dec;
					if (skip_dec == 16'd0) phase_n = jfhs_pkg::PH_WANTFF;
				end
				jfhs_pkg::PH_PREC: begin
					phase_n = jfhs_pkg::PH_HHI;
				end
				jfhs_pkg::PH_HHI: begin
					height_n = {b, 8'd0};
					phase_n  = jfhs_pkg::PH_HLO;
				end
				jfhs_pkg::PH_HLO: begin
					height_n = {height_q[15:8], b};
					phase_n  = jfhs_pkg::PH_WHI;
				end
				jfhs_pkg::PH_WHI: begin
					width_hi_n = b;
					phase_n    = jfhs_pkg::PH_WLO;
				end
				default: begin
					// last width byte
					if (wval == 16'd0 || height_q == 16'd0) fail = 1'b1;
					else win = 1'b1;
				end
			endcase
			// limit hit on this byte with nothing settled yet
			if (!fail && !win && cnt_inc >= {1'b0, byte_limit}) fail = 1'b1;
		end
		if (!fail && !win && beat.last_byte && !decided_q) fail = 1'b1;
	end

	assign res_fire        = fail || win;
	assign res.ok          = win;
	assign res.width       = win ? wval : 16'd0;
	assign res.height      = win ? height_q : 16'd0;
	assign res.progressive = win && jfhs_pkg::prog_code(marker_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= jfhs_pkg::PH_SOI0;
			byte_count_q <= 16'd0;
			skip_left_q  <= 16'd0;
			marker_q     <= 8'd0;
			len_hi_q     <= 8'd0;
			height_q     <= 16'd0;
			width_hi_q   <= 8'd0;
			decided_q    <= 1'b0;
		end else if (step) begin
			if (beat.last_byte) begin
				phase_q      <= jfhs_pkg::PH_SOI0;
				byte_count_q <= 16'd0;
				skip_left_q  <= 16'd0;
				marker_q     <= 8'd0;
				len_hi_q     <= 8'd0;
				height_q     <= 16'd0;
				width_hi_q   <= 8'd0;
				decided_q    <= 1'b0;
			end else begin
				phase_q     <= phase_n;
				skip_left_q <= skip_left_n;
				marker_q    <= marker_n;
				len_hi_q    <= len_hi_n;
				height_q    <= height_n;
				width_hi_q  <= width_hi_n;
				decided_q   <= decided_q || res_fire;
				if (take) byte_count_q <= cnt_inc[15:0];
			end
		end
	end

endmodule

@@ rtl/core/jfhs_cfg.sv @@
// jfhs_cfg: byte_limit register behind its own write channel.
// Depends on nothing but jfhs_pkg.
module jfhs_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic [15:0] byte_limit
);

	logic [15:0] limit_q;

	assign cfg_ready  = 1'b1;
	assign byte_limit = limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= jfhs_pkg::LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

endmodule

@@ rtl/core/jfhs_checker.sv @@
// jfhs_checker: port-level assertions for jpeg_frame_header_scanner_core,
// bound to the top level below. Depends on jfhs_pkg.
module jfhs_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input jfhs_pkg::out_t  out_data,
	input logic            cfg_valid,
	input logic            cfg_ready
);

	// a held result beat does not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// failure beats carry no sizes and no progressive flag
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.ok |->
			out_data.width == 16'd0 && out_data.height == 16'd0 &&
			!out_data.progressive)
		else $error("failure beat with nonzero fields");

	// success needs both sizes nonzero
	a_ok_sizes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.ok |->
			out_data.width != 16'd0 && out_data.height != 16'd0)
		else $error("success beat with a zero size");

	// a result can only follow a byte taken in an earlier cycle
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid, 2) || $past(in_valid) ||
			!$past(in_ready, 2))
		else $error("result beat without a preceding byte");

	// config channel never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind jpeg_frame_header_scanner_core jfhs_checker u_jfhs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
